// ===== src/servo_status_packet_receiver_defines.svh =====
// Assertion macros for the servo status packet receiver
`ifndef SERVO_STATUS_PACKET_RECEIVER_DEFINES_SVH
`define SERVO_STATUS_PACKET_RECEIVER_DEFINES_SVH

// same-cycle implication, held off during reset
`define SSPR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sspr assertion failed");

// next-cycle implication, held off during reset
`define SSPR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sspr assertion failed");

`endif

// ===== src/sspr_pkg.sv =====
// Types and constants shared by the servo status packet receiver
package sspr_pkg;

    localparam int MaxData  = 16;
    localparam int AddrW    = $clog2(MaxData);
    localparam int CntW     = $clog2(MaxData + 1);
    localparam int DataIdxW = 4;

    localparam logic [7:0] HDR_BYTE  = 8'hFF;
    localparam logic [7:0] LEN_EXTRA = 8'd2;

    localparam logic [1:0] OP_ARM  = 2'd0;
    localparam logic [1:0] OP_BYTE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] CFG_HEADER_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [1:0] CFG_BROADCAST_ID  = 2'd2;

    localparam logic [3:0]  RST_HEADER_LIMIT  = 4'd10;
    localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd100;
    localparam logic [7:0]  RST_BROADCAST_ID  = 8'd254;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_HEADER = 3'd1,
        ST_TIMEOUT   = 3'd2,
        ST_WRONG_ID  = 3'd3,
        ST_WRONG_LEN = 3'd4,
        ST_BAD_SUM   = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
        logic [7:0] expected_id;
        logic [4:0] expected_len;
        logic       check_id;
        logic       check_length;
    } in_t;

    typedef struct packed {
        logic                has_data;
        logic [DataIdxW-1:0] data_index;
        logic [7:0]          data_byte;
        logic [2:0]          status;
        logic [7:0]          responder_id;
        logic [7:0]          error_flags;
        logic                last;
    } out_t;

endpackage

// ===== src/sspr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read
module sspr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/servo_status_packet_receiver.sv =====
// Servo bus status packet receiver: header hunt, field capture, checks, result run
// Input: one word per cycle while no result run is pending; s_ready drops while a run drains.
// Result run: the ending word sets drain_busy_reg; a final-only run then goes to m_valid_reg,
// while a data run first reads the data store (registered read, rd_ok_reg/rd_tag_reg), then gives
// one result per cycle while m_ready holds; s_ready stays low until the final word is issued.
// Reset: synchronous, active low; registers return to defaults, receiver idle, no run.
`include "servo_status_packet_receiver_defines.svh"

module servo_status_packet_receiver (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  sspr_pkg::in_t     s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sspr_pkg::out_t    m_data
);
    import sspr_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HUNT,
        PH_ID,
        PH_LEN,
        PH_ERR,
        PH_DATA,
        PH_SUM
    } phase_t;

    // configuration
    logic [3:0]  header_limit_reg;
    logic [15:0] timeout_ticks_reg;
    logic [7:0]  broadcast_id_reg;

    // transaction state
    phase_t         phase_reg, phase_next;
    logic           prev_ff_reg, prev_ff_next;
    logic [3:0]     hunt_count_reg, hunt_count_next;
    logic [15:0]    gap_reg, gap_next;
    logic [7:0]     want_id_reg, want_id_next;
    logic [CntW-1:0] want_len_reg, want_len_next;
    logic           chk_id_reg, chk_id_next;
    logic           chk_len_reg, chk_len_next;
    logic [7:0]     got_id_reg, got_id_next;
    logic [7:0]     got_len_reg, got_len_next;
    logic [7:0]     got_err_reg, got_err_next;
    logic [7:0]     sum_reg, sum_next;
    logic [CntW-1:0] data_count_reg, data_count_next;

    // result run
    logic            drain_busy_reg, drain_busy_next;
    logic [CntW-1:0] drain_idx_reg, drain_idx_next;
    logic [CntW-1:0] drain_len_reg, drain_len_next;
    status_t         fin_status_reg, fin_status_next;
    logic            rd_ok_reg, rd_ok_next;
    logic [CntW-1:0] rd_tag_reg, rd_tag_next;
    logic            m_valid_reg, m_valid_next;
    out_t            m_data_reg, m_data_next;

    logic            accept;
    logic            fin;
    status_t         fin_code;
    logic [CntW-1:0] arm_len;
    logic [15:0]     gap_inc;
    logic            id_ok;
    logic            len_ok;
    logic            out_free;
    logic            drain_in_data;
    logic            rd_hit;
    logic            emit_data;
    logic            emit_final;
    logic            mem_we;
    logic [7:0]      rd_data;
    logic [CntW-1:0] drain_idx_inc;

    assign accept  = s_valid && s_ready;
    assign s_ready = !drain_busy_reg;
    assign arm_len = (s_data.expected_len > CntW'(MaxData)) ? CntW'(MaxData)
                                                            : CntW'(s_data.expected_len);
    assign gap_inc = (gap_reg == 16'hFFFF) ? gap_reg : gap_reg + 16'd1;
    assign id_ok   = !chk_id_reg || (want_id_reg == broadcast_id_reg)
                     || (got_id_reg == want_id_reg);
    assign len_ok  = !chk_len_reg || (got_len_reg == {{(8-CntW){1'b0}}, want_len_reg} + LEN_EXTRA);
    assign mem_we  = accept && (s_data.operation == OP_BYTE) && (phase_reg == PH_DATA);

    // packet parser
    always_comb begin
        phase_next      = phase_reg;
        prev_ff_next    = prev_ff_reg;
        hunt_count_next = hunt_count_reg;
        gap_next        = gap_reg;
        want_id_next    = want_id_reg;
        want_len_next   = want_len_reg;
        chk_id_next     = chk_id_reg;
        chk_len_next    = chk_len_reg;
        got_id_next     = got_id_reg;
        got_len_next    = got_len_reg;
        got_err_next    = got_err_reg;
        sum_next        = sum_reg;
        data_count_next = data_count_reg;
        fin             = 1'b0;
        fin_code        = ST_OK;

        if (accept) begin
            if (s_data.operation == OP_ARM) begin
                want_id_next    = s_data.expected_id;
                want_len_next   = arm_len;
                chk_id_next     = s_data.check_id;
                chk_len_next    = s_data.check_length;
                phase_next      = PH_HUNT;
                prev_ff_next    = 1'b0;
                hunt_count_next = 4'd0;
                gap_next        = 16'd0;
                got_id_next     = 8'd0;
                got_len_next    = 8'd0;
                got_err_next    = 8'd0;
                sum_next        = 8'd0;
                data_count_next = '0;
            end else if (phase_reg != PH_IDLE) begin
                if (s_data.operation == OP_BYTE) begin
                    gap_next = 16'd0;
                    unique case (phase_reg)
                        PH_HUNT: begin
                            if (s_data.rx_byte == HDR_BYTE && prev_ff_reg) begin
                                prev_ff_next = 1'b0;
                                phase_next   = PH_ID;
                            end else begin
                                prev_ff_next = (s_data.rx_byte == HDR_BYTE);
                                if (hunt_count_reg >= header_limit_reg) begin
                                    fin      = 1'b1;
                                    fin_code = ST_NO_HEADER;
                                end else begin
                                    hunt_count_next = hunt_count_reg + 4'd1;
                                end
                            end
                        end
                        PH_ID: begin
                            got_id_next = s_data.rx_byte;
                            sum_next    = s_data.rx_byte;
                            phase_next  = PH_LEN;
                        end
                        PH_LEN: begin
                            got_len_next = s_data.rx_byte;
                            sum_next     = sum_reg + s_data.rx_byte;
                            phase_next   = PH_ERR;
                        end
                        PH_ERR: begin
                            got_err_next = s_data.rx_byte;
                            sum_next     = sum_reg + s_data.rx_byte;
                            phase_next   = (want_len_reg == '0) ? PH_SUM : PH_DATA;
                        end
                        PH_DATA: begin
                            sum_next        = sum_reg + s_data.rx_byte;
                            data_count_next = data_count_reg + CntW'(1);
                            if (data_count_next >= want_len_reg) begin
                                phase_next = PH_SUM;
                            end
                        end
                        PH_SUM: begin
                            fin = 1'b1;
                            priority if (!id_ok) begin
                                fin_code = ST_WRONG_ID;
                            end else if (!len_ok) begin
                                fin_code = ST_WRONG_LEN;
                            end else if (~sum_reg != s_data.rx_byte) begin
                                fin_code = ST_BAD_SUM;
                            end else begin
                                fin_code = ST_OK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (s_data.operation == OP_TICK) begin
                    gap_next = gap_inc;
                    if (gap_inc >= timeout_ticks_reg) begin
                        fin      = 1'b1;
                        fin_code = ST_TIMEOUT;
                    end
                end
            end
        end

        if (fin) begin
            phase_next      = PH_IDLE;
            prev_ff_next    = 1'b0;
            hunt_count_next = 4'd0;
            gap_next        = 16'd0;
        end
    end

    // result run: data words read from the store, then the final word
    assign out_free      = !m_valid_reg || m_ready;
    assign drain_in_data = drain_idx_reg < drain_len_reg;
    assign rd_hit        = rd_ok_reg && (rd_tag_reg == drain_idx_reg);
    assign emit_data     = drain_busy_reg && drain_in_data && rd_hit && out_free;
    assign emit_final    = drain_busy_reg && !drain_in_data && out_free;
    assign drain_idx_inc = drain_idx_reg + CntW'(1);
    // look one entry ahead when a data word leaves, so the store keeps up
    assign rd_tag_next   = emit_data ? drain_idx_inc : drain_idx_reg;
    assign rd_ok_next    = drain_busy_reg && !emit_final;

    always_comb begin
        drain_busy_next = drain_busy_reg;
        drain_idx_next  = drain_idx_reg;
        drain_len_next  = drain_len_reg;
        fin_status_next = fin_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        if (fin) begin
            drain_busy_next = 1'b1;
            drain_idx_next  = '0;
            drain_len_next  = (fin_code == ST_OK) ? want_len_reg : '0;
            fin_status_next = fin_code;
        end

        if (emit_data) begin
            drain_idx_next           = drain_idx_inc;
            m_valid_next             = 1'b1;
            m_data_next              = '0;
            m_data_next.has_data     = 1'b1;
            m_data_next.data_index   = drain_idx_reg[DataIdxW-1:0];
            m_data_next.data_byte    = rd_data;
        end else if (emit_final) begin
            drain_busy_next          = 1'b0;
            m_valid_next             = 1'b1;
            m_data_next              = '0;
            m_data_next.status       = fin_status_reg;
            m_data_next.responder_id = got_id_reg;
            m_data_next.error_flags  = (fin_status_reg == ST_OK) ? got_err_reg : 8'd0;
            m_data_next.last         = 1'b1;
        end
    end

    sspr_ram #(
        .WIDTH (8),
        .DEPTH (MaxData)
    ) u_data_store (
        .clk     (aclk),
        .wr_en   (mem_we),
        .wr_addr (data_count_reg[AddrW-1:0]),
        .wr_data (s_data.rx_byte),
        .rd_addr (rd_tag_next[AddrW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_limit_reg  <= RST_HEADER_LIMIT;
            timeout_ticks_reg <= RST_TIMEOUT_TICKS;
            broadcast_id_reg  <= RST_BROADCAST_ID;
            phase_reg         <= PH_IDLE;
            prev_ff_reg       <= 1'b0;
            hunt_count_reg    <= 4'd0;
            gap_reg           <= 16'd0;
            want_id_reg       <= 8'd0;
            want_len_reg      <= '0;
            chk_id_reg        <= 1'b0;
            chk_len_reg       <= 1'b0;
            got_id_reg        <= 8'd0;
            got_len_reg       <= 8'd0;
            got_err_reg       <= 8'd0;
            sum_reg           <= 8'd0;
            data_count_reg    <= '0;
            drain_busy_reg    <= 1'b0;
            drain_idx_reg     <= '0;
            drain_len_reg     <= '0;
            fin_status_reg    <= ST_OK;
            rd_ok_reg         <= 1'b0;
            rd_tag_reg        <= '0;
            m_valid_reg       <= 1'b0;
            m_data_reg        <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_HEADER_LIMIT:  header_limit_reg  <= cfg_wdata[3:0];
                    CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_wdata;
                    CFG_BROADCAST_ID:  broadcast_id_reg  <= cfg_wdata[7:0];
                    default: begin
                    end
                endcase
            end
            phase_reg      <= phase_next;
            prev_ff_reg    <= prev_ff_next;
            hunt_count_reg <= hunt_count_next;
            gap_reg        <= gap_next;
            want_id_reg    <= want_id_next;
            want_len_reg   <= want_len_next;
            chk_id_reg     <= chk_id_next;
            chk_len_reg    <= chk_len_next;
            got_id_reg     <= got_id_next;
            got_len_reg    <= got_len_next;
            got_err_reg    <= got_err_next;
            sum_reg        <= sum_next;
            data_count_reg <= data_count_next;
            drain_busy_reg <= drain_busy_next;
            drain_idx_reg  <= drain_idx_next;
            drain_len_reg  <= drain_len_next;
            fin_status_reg <= fin_status_next;
            rd_ok_reg      <= rd_ok_next;
            rd_tag_reg     <= rd_tag_next;
            m_valid_reg    <= m_valid_next;
            m_data_reg     <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SSPR_ASSERT_NOW(a_run_blocks_input, aclk, aresetn, drain_busy_reg, !s_ready)
    `SSPR_ASSERT_NOW(a_run_when_idle, aclk, aresetn, drain_busy_reg, phase_reg == PH_IDLE)
    `SSPR_ASSERT_NOW(a_data_in_range, aclk, aresetn, phase_reg == PH_DATA, data_count_reg < want_len_reg)
    `SSPR_ASSERT_NEXT(a_final_ends_run, aclk, aresetn, emit_final, !drain_busy_reg && m_valid && m_data.last)

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the servo status packet receiver
`timescale 1ns / 100ps

module tb;
    import sspr_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         QUIET_LIMIT = 3000;
    localparam int         SETTLE_CYC  = 40;
    localparam int         LONG_STALL  = 400;

    typedef enum logic [2:0] {
        RX_IDLE, RX_HUNT, RX_ID, RX_LEN, RX_ERR, RX_DATA, RX_SUM
    } rx_phase_t;

    typedef struct {
        in_t        word;
        bit         typed;
        status_t    st;
        logic [7:0] rid;
        logic [7:0] err;
    } dir_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_HEADER_LIMIT;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_t         s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_t        m_data;

    servo_status_packet_receiver u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // register shadow
    logic [3:0]  cfg_hdr_limit = RST_HEADER_LIMIT;
    logic [15:0] cfg_timeout   = RST_TIMEOUT_TICKS;
    logic [7:0]  cfg_bcast     = RST_BROADCAST_ID;

    // receiver shadow
    rx_phase_t   rx_ph      = RX_IDLE;
    logic        rx_prev_ff = 1'b0;
    logic [3:0]  rx_hunt    = '0;
    logic [15:0] rx_gap     = '0;
    logic [7:0]  rx_want_id = '0;
    logic [4:0]  rx_want_len = '0;
    logic        rx_chk_id  = 1'b0;
    logic        rx_chk_len = 1'b0;
    logic [7:0]  rx_got_id  = '0;
    logic [7:0]  rx_got_len = '0;
    logic [7:0]  rx_got_err = '0;
    logic [7:0]  rx_sum     = '0;
    logic [4:0]  rx_count   = '0;
    logic [7:0]  rx_data [MaxData];

    out_t        reply_due[$];
    int          mismatches     = 0;
    int          quiet          = 0;
    int unsigned words_taken    = 0;
    int unsigned runs_closed    = 0;
    int unsigned burst_left     = 0;
    logic        long_stall_req = 1'b0;
    dir_row_t    dir_rows [28];

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic in_t make_word(input logic [1:0] op, input logic [7:0] b,
                                      input logic [7:0] id, input logic [4:0] len,
                                      input logic cid, input logic clen);
        in_t w;
        w.operation    = op;
        w.rx_byte      = b;
        w.expected_id  = id;
        w.expected_len = len;
        w.check_id     = cid;
        w.check_length = clen;
        return w;
    endfunction

    function automatic in_t arm_word(input logic [7:0] id, input logic [4:0] len,
                                     input logic cid, input logic clen);
        return make_word(OP_ARM, 8'h00, id, len, cid, clen);
    endfunction

    function automatic in_t byte_word(input logic [7:0] b);
        return make_word(OP_BYTE, b, 8'h00, 5'd0, 1'b0, 1'b0);
    endfunction

    function automatic out_t status_word(input status_t st, input logic [7:0] rid,
                                         input logic [7:0] err);
        out_t r;
        r              = '0;
        r.status       = st;
        r.responder_id = rid;
        r.error_flags  = err;
        r.last         = 1'b1;
        return r;
    endfunction

    // ends the transaction and queues its result run
    task automatic close_reply(input status_t st);
        out_t r;
        if (st == ST_OK) begin
            for (int i = 0; i < rx_want_len; i++) begin
                r            = '0;
                r.has_data   = 1'b1;
                r.data_index = i[DataIdxW-1:0];
                r.data_byte  = rx_data[i];
                reply_due.push_back(r);
            end
        end
        reply_due.push_back(status_word(st, rx_got_id, st == ST_OK ? rx_got_err : 8'h00));
        runs_closed++;
        rx_ph      = RX_IDLE;
        rx_prev_ff = 1'b0;
        rx_hunt    = '0;
        rx_gap     = '0;
    endtask

    task automatic take_line_byte(input logic [7:0] b);
        logic [7:0] want_sum;
        want_sum = ~rx_sum;
        rx_gap   = '0;
        case (rx_ph)
            RX_HUNT: begin
                if (b == HDR_BYTE && rx_prev_ff) begin
                    rx_prev_ff = 1'b0;
                    rx_ph      = RX_ID;
                end else begin
                    rx_prev_ff = (b == HDR_BYTE);
                    if (rx_hunt >= cfg_hdr_limit) close_reply(ST_NO_HEADER);
                    else rx_hunt = rx_hunt + 4'd1;
                end
            end
            RX_ID: begin
                rx_got_id = b;
                rx_sum    = b;
                rx_ph     = RX_LEN;
            end
            RX_LEN: begin
                rx_got_len = b;
                rx_sum     = rx_sum + b;
                rx_ph      = RX_ERR;
            end
            RX_ERR: begin
                rx_got_err = b;
                rx_sum     = rx_sum + b;
                rx_ph      = (rx_want_len == 0) ? RX_SUM : RX_DATA;
            end
            RX_DATA: begin
                if (rx_count < MaxData) rx_data[rx_count[AddrW-1:0]] = b;
                rx_sum   = rx_sum + b;
                rx_count = rx_count + 5'd1;
                if (rx_count >= rx_want_len) rx_ph = RX_SUM;
            end
            RX_SUM: begin
                // id beats length beats checksum
                if (rx_chk_id && rx_want_id != cfg_bcast && rx_got_id != rx_want_id)
                    close_reply(ST_WRONG_ID);
                else if (rx_chk_len && rx_got_len != {3'b000, rx_want_len} + LEN_EXTRA)
                    close_reply(ST_WRONG_LEN);
                else if (want_sum != b)
                    close_reply(ST_BAD_SUM);
                else
                    close_reply(ST_OK);
            end
            default: ;
        endcase
    endtask

    task automatic predict_reply(input in_t w);
        if (w.operation == OP_ARM) begin
            rx_want_id  = w.expected_id;
            rx_want_len = (w.expected_len > MaxData) ? 5'(MaxData) : w.expected_len;
            rx_chk_id   = w.check_id;
            rx_chk_len  = w.check_length;
            rx_ph       = RX_HUNT;
            rx_prev_ff  = 1'b0;
            rx_hunt     = '0;
            rx_gap      = '0;
            rx_got_id   = '0;
            rx_got_len  = '0;
            rx_got_err  = '0;
            rx_sum      = '0;
            rx_count    = '0;
        end else if (rx_ph != RX_IDLE) begin
            if (w.operation == OP_BYTE) begin
                take_line_byte(w.rx_byte);
            end else if (w.operation == OP_TICK) begin
                if (rx_gap != 16'hFFFF) rx_gap = rx_gap + 16'd1;
                if (rx_gap >= cfg_timeout) close_reply(ST_TIMEOUT);
            end
        end
    endtask

    // bursts of words with random gaps in between
    task automatic send_word(input in_t w);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        if (w.operation == OP_ARM || (rx_ph != RX_IDLE && w.operation != OP_UNUSED))
            words_taken++;
        predict_reply(w);
    endtask

    task automatic sender_rest();
        s_valid    <= 1'b0;
        burst_left = 0;
    endtask

    task automatic settle();
        while (reply_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [3:0] hl, input logic [15:0] to,
                              input logic [7:0] bc);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_HEADER_LIMIT;
        cfg_wdata <= {12'd0, hl};
        @(posedge aclk);
        cfg_index <= CFG_TIMEOUT_TICKS;
        cfg_wdata <= to;
        @(posedge aclk);
        cfg_index <= CFG_BROADCAST_ID;
        cfg_wdata <= {8'd0, bc};
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        cfg_hdr_limit = hl;
        cfg_timeout   = to;
        cfg_bcast     = bc;
    endtask

    // occasional ticks ahead of a line byte
    task automatic send_line_byte(input logic [7:0] b);
        if ($urandom_range(0, 11) == 0)
            repeat ($urandom_range(1, 4))
                send_word(make_word(OP_TICK, 8'($urandom), 8'h00, 5'd0, 1'b0, 1'b0));
        send_word(byte_word(b));
    endtask

    // arm, line noise, header, id, length, error, data, checksum
    task automatic send_reply_frame();
        logic [7:0]  id, rid, lenb, err, sum, d;
        logic [4:0]  len;
        logic        cid, clen;
        int unsigned eff, junk, cut, pick;
        logic [7:0]  line_q[$];
        id   = ($urandom_range(0, 7) == 0) ? cfg_bcast : 8'($urandom);
        pick = $urandom_range(0, 19);
        len  = (pick < 17) ? 5'($urandom_range(0, 4)) :
               (pick < 19) ? 5'($urandom_range(5, 16)) : 5'($urandom_range(17, 31));
        eff  = (len > MaxData) ? MaxData : len;
        cid  = 1'($urandom);
        clen = 1'($urandom);
        send_word(arm_word(id, len, cid, clen));
        junk = ($urandom_range(0, 6) == 0) ? cfg_hdr_limit + 1 :
               $urandom_range(0, cfg_hdr_limit);
        repeat (junk) line_q.push_back(8'($urandom));
        line_q.push_back(HDR_BYTE);
        line_q.push_back(HDR_BYTE);
        rid  = ($urandom_range(0, 4) == 0) ? 8'($urandom) : id;
        lenb = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'(eff + 2);
        err  = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
        line_q.push_back(rid);
        line_q.push_back(lenb);
        line_q.push_back(err);
        sum = rid + lenb + err;
        repeat (eff) begin
            d   = 8'($urandom);
            sum = sum + d;
            line_q.push_back(d);
        end
        line_q.push_back(($urandom_range(0, 6) == 0) ? 8'($urandom) : ~sum);
        // now and then the frame is cut short and the next arm lands mid-reply
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, line_q.size() - 1) :
              line_q.size();
        for (int i = 0; i < cut; i++) send_line_byte(line_q[i]);
    endtask

    // result sink: stall pattern by time slice, plus one long hold-off on request
    initial begin : result_sink
        int unsigned hold_left;
        int unsigned cyc;
        hold_left = 0;
        cyc       = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (hold_left == 0 && long_stall_req) begin
                long_stall_req = 1'b0;
                hold_left      = LONG_STALL;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case ((cyc >> 7) % 4)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom);
                    2: m_ready <= (cyc % 4 != 0);
                    default: m_ready <= ($urandom_range(0, 6) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : result_check
        out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                quiet = 0;
                if (reply_due.size() == 0) begin
                    flag_mismatch("result with nothing due", 32'(m_data), 0);
                end else begin
                    want = reply_due.pop_front();
                    if (m_data.has_data !== want.has_data)
                        flag_mismatch("has_data", 32'(m_data.has_data),
                                      32'(want.has_data));
                    if (m_data.data_index !== want.data_index)
                        flag_mismatch("data_index", 32'(m_data.data_index),
                                      32'(want.data_index));
                    if (m_data.data_byte !== want.data_byte)
                        flag_mismatch("data_byte", 32'(m_data.data_byte),
                                      32'(want.data_byte));
                    if (m_data.status !== want.status)
                        flag_mismatch("status", 32'(m_data.status), 32'(want.status));
                    if (m_data.responder_id !== want.responder_id)
                        flag_mismatch("responder_id", 32'(m_data.responder_id),
                                      32'(want.responder_id));
                    if (m_data.error_flags !== want.error_flags)
                        flag_mismatch("error_flags", 32'(m_data.error_flags),
                                      32'(want.error_flags));
                    if (m_data.last !== want.last)
                        flag_mismatch("last", 32'(m_data.last), 32'(want.last));
                end
            end else if (s_valid && s_ready) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned n;
        int unsigned phase_end;
        dir_rows = '{
            '{byte_word(8'h55), 1'b0, ST_OK, 8'h00, 8'h00},
            '{make_word(OP_TICK, 8'h00, 8'h00, 5'd0, 1'b0, 1'b0), 1'b0, ST_OK, 8'h00, 8'h00},
            '{make_word(OP_UNUSED, 8'hFF, 8'hFF, 5'd31, 1'b1, 1'b1), 1'b0, ST_OK, 8'h00, 8'h00},
            '{arm_word(8'hFF, 5'd31, 1'b1, 1'b1), 1'b0, ST_OK, 8'h00, 8'h00},
            // re-arm while busy, then a clean zero-length reply
            '{arm_word(8'h01, 5'd0, 1'b1, 1'b1), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'hFF), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'hFF), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'h01), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'h02), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'h80), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'h7C), 1'b1, ST_OK, 8'h01, 8'h80},
            // id, length and checksum all wrong: id wins
            '{arm_word(8'h07, 5'd1, 1'b1, 1'b1), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'hFF), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'hFF), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'h08), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'h05), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'h00), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'h00), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'h00), 1'b1, ST_WRONG_ID, 8'h08, 8'h00},
            // broadcast id skips the id check
            '{arm_word(8'hFE, 5'd2, 1'b1, 1'b1), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'hFF), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'hFF), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'h33), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'h04), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'hFF), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'h00), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'hFF), 1'b0, ST_OK, 8'h00, 8'h00},
            '{byte_word(8'hCA), 1'b0, ST_OK, 8'h00, 8'h00}
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            n = runs_closed;
            send_word(dir_rows[i].word);
            if (dir_rows[i].typed) begin
                if (runs_closed != n) void'(reply_due.pop_back());
                reply_due.push_back(status_word(dir_rows[i].st, dir_rows[i].rid,
                                                dir_rows[i].err));
            end
        end
        sender_rest();
        settle();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: write_regs(4'd0, 16'd0, 8'h00);
                1: write_regs(4'd15, 16'hFFFF, 8'hFF);
                2: write_regs(4'd1, 16'd1, 8'h80);
                3: write_regs(4'($urandom_range(1, 15)), 16'($urandom_range(2, 6)),
                              8'($urandom));
                4: write_regs(4'($urandom), 16'($urandom_range(7, 65535)), 8'($urandom));
                default: write_regs(RST_HEADER_LIMIT, RST_TIMEOUT_TICKS, RST_BROADCAST_ID);
            endcase
            // back up the result side so the input stalls
            if (p == 1) long_stall_req = 1'b1;
            phase_end = words_taken + 85;
            while (words_taken < phase_end) begin
                if ($urandom_range(0, 9) == 0)
                    send_word(make_word(2'($urandom), 8'($urandom), 8'($urandom),
                                        5'($urandom), 1'($urandom), 1'($urandom)));
                else
                    send_reply_frame();
            end
            sender_rest();
            settle();
        end

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== servo_status_packet_receiver.f =====
+incdir+src
src/sspr_pkg.sv
src/sspr_ram.sv
src/servo_status_packet_receiver.sv
verif/tb.sv
